FILE: hw/rtl/tdfa_pkg.sv
package tdfa_pkg;

  localparam int unsigned OpcodeW = 3;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned DataW   = 8;
  localparam int unsigned CfgW    = 6;
  localparam int unsigned StateW  = 5;

  localparam logic [OpcodeW-1:0] OP_LOAD_LETTER = 3'd0;
  localparam logic [OpcodeW-1:0] OP_LOAD_FINAL  = 3'd1;
  localparam logic [OpcodeW-1:0] OP_LOAD_TRANS  = 3'd2;
  localparam logic [OpcodeW-1:0] OP_START       = 3'd3;
  localparam logic [OpcodeW-1:0] OP_SYMBOL      = 3'd4;

  localparam logic REG_STATES  = 1'b0;
  localparam logic REG_LETTERS = 1'b1;

  typedef enum logic [2:0] {
    KIND_LETTER,
    KIND_FINAL,
    KIND_TRANS,
    KIND_START,
    KIND_SYMBOL,
    KIND_NOP
  } tdfa_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_FETCH
  } tdfa_back_state_e;

  typedef struct packed {
    tdfa_kind_e         kind;
    logic [SlotW-1:0]   slot;
    logic [SlotW-1:0]   lslot;
    logic [DataW-1:0]   data;
  } tdfa_op_t;

  typedef struct packed {
    logic [CfgW-1:0] states_in_use;
    logic [CfgW-1:0] letters_in_use;
  } tdfa_cfg_t;

endpackage

FILE: hw/rtl/tdfa_front.sv
module tdfa_front
  import tdfa_pkg::*;
#(
  parameter int unsigned MAX_STATES  = 32,
  parameter int unsigned MAX_LETTERS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpcodeW-1:0] in_opcode_i,
  input  logic [SlotW-1:0]   in_slot_i,
  input  logic [SlotW-1:0]   in_lslot_i,
  input  logic [DataW-1:0]   in_data_i,
  output logic               op_valid_o,
  output tdfa_op_t           op_o,
  input  logic               pop_i
);

  logic [8:0] slot_ext;
  logic [8:0] lslot_ext;
  logic       slot_state_ok;
  logic       slot_letter_ok;
  logic       lslot_ok;
  tdfa_op_t   op_new;
  tdfa_op_t   entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  assign slot_ext       = {4'b0, in_slot_i};
  assign lslot_ext      = {4'b0, in_lslot_i};
  assign slot_state_ok  = slot_ext < 9'(MAX_STATES);
  assign slot_letter_ok = slot_ext < 9'(MAX_LETTERS);
  assign lslot_ok       = lslot_ext < 9'(MAX_LETTERS);

  // Loads aimed beyond the tables are turned into no-operations here.
  always_comb begin
    op_new.slot  = in_slot_i;
    op_new.lslot = in_lslot_i;
    op_new.data  = in_data_i;
    unique case (in_opcode_i)
      OP_LOAD_LETTER: op_new.kind = slot_letter_ok ? KIND_LETTER : KIND_NOP;
      OP_LOAD_FINAL:  op_new.kind = slot_state_ok ? KIND_FINAL : KIND_NOP;
      OP_LOAD_TRANS:  op_new.kind = (slot_state_ok && lslot_ok) ? KIND_TRANS : KIND_NOP;
      OP_START:       op_new.kind = KIND_START;
      OP_SYMBOL:      op_new.kind = KIND_SYMBOL;
      default:        op_new.kind = KIND_NOP;
    endcase
  end

  assign in_ready_o = count_q != 2'd2;
  assign push       = in_valid_i && in_ready_o;
  assign op_valid_o = count_q != 2'd0;
  assign op_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

FILE: hw/rtl/tdfa_back.sv
module tdfa_back
  import tdfa_pkg::*;
#(
  parameter int unsigned MAX_STATES  = 32,
  parameter int unsigned MAX_LETTERS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdfa_cfg_t         cfg_i,
  input  logic              op_valid_i,
  input  tdfa_op_t          op_i,
  output logic              pop_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [StateW-1:0] out_state_o,
  output logic              out_accept_o,
  output logic              out_illegal_o
);

  localparam int unsigned SW    = $clog2(MAX_STATES);
  localparam int unsigned LW    = $clog2(MAX_LETTERS);
  localparam int unsigned Depth = MAX_STATES * MAX_LETTERS;
  localparam int unsigned AW    = $clog2(Depth);

  tdfa_back_state_e  bk_q, bk_d;
  logic [DataW-1:0]  alpha_q [MAX_LETTERS];
  logic [MAX_STATES-1:0] final_q;
  logic [DataW-1:0]  trans_mem [Depth];
  logic [DataW-1:0]  next_q;
  logic [SW-1:0]     state_q, state_d;
  logic              ill_q, ill_d;
  logic              out_valid_q;
  logic [StateW-1:0] out_state_q;
  logic              out_acc_q;
  logic              out_ill_q;

  logic [8:0]        slot_ext;
  logic [8:0]        lslot_ext;
  logic [8:0]        next_ext;
  logic [8:0]        state_ext;
  logic [SW-1:0]     fs_idx;
  logic [LW-1:0]     ls_idx;
  logic [LW-1:0]     hit_idx;
  logic              found;
  logic              next_ok;
  logic              out_free;
  logic              dispatch;
  logic              go_fetch;
  logic              alpha_we;
  logic              final_we;
  logic              mem_we;
  logic              mem_re;
  logic              res_load;
  logic              mark;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;

  assign slot_ext  = {4'b0, op_i.slot};
  assign lslot_ext = {4'b0, op_i.lslot};
  assign fs_idx    = slot_ext[SW-1:0];
  assign ls_idx    = slot_ext[LW-1:0];
  assign next_ext  = {1'b0, next_q};
  assign next_ok   = (next_ext < {3'b0, cfg_i.states_in_use}) &&
                     (next_ext < 9'(MAX_STATES));

  // The first matching entry among the letters in use wins.
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int j = MAX_LETTERS - 1; j >= 0; j--) begin
      if (alpha_q[j] == op_i.data && j < int'(cfg_i.letters_in_use)) begin
        found   = 1'b1;
        hit_idx = LW'(j);
      end
    end
  end

  assign raddr    = AW'(int'(state_q) * MAX_LETTERS + int'(hit_idx));
  assign waddr    = AW'(int'(fs_idx) * MAX_LETTERS + int'(lslot_ext[LW-1:0]));
  assign out_free = !out_valid_q || out_ready_i;
  assign dispatch = (bk_q == BK_IDLE) && op_valid_i && out_free;
  assign go_fetch = dispatch && (op_i.kind == KIND_SYMBOL) && !ill_q && found;

  always_comb begin
    bk_d = bk_q;
    unique case (bk_q)
      BK_IDLE: begin
        if (go_fetch) begin
          bk_d = BK_FETCH;
        end
      end
      BK_FETCH: begin
        if (out_free) begin
          bk_d = BK_IDLE;
        end
      end
      default: bk_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    alpha_we = 1'b0;
    final_we = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    res_load = 1'b0;
    state_d  = state_q;
    ill_d    = ill_q;
    unique case (bk_q)
      BK_IDLE: begin
        if (dispatch) begin
          pop_o = 1'b1;
          unique case (op_i.kind)
            KIND_LETTER: begin
              alpha_we = 1'b1;
              res_load = 1'b1;
            end
            KIND_FINAL: begin
              final_we = 1'b1;
              res_load = 1'b1;
            end
            KIND_TRANS: begin
              mem_we   = 1'b1;
              res_load = 1'b1;
            end
            KIND_START: begin
              state_d  = '0;
              ill_d    = 1'b0;
              res_load = 1'b1;
            end
            KIND_SYMBOL: begin
              if (ill_q) begin
                res_load = 1'b1;
              end else if (!found) begin
                ill_d    = 1'b1;
                res_load = 1'b1;
              end else begin
                mem_re = 1'b1;
              end
            end
            KIND_NOP: begin
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      BK_FETCH: begin
        if (out_free) begin
          res_load = 1'b1;
          if (next_ok) begin
            state_d = next_ext[SW-1:0];
          end else begin
            ill_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign mark      = (final_we && fs_idx == state_d) ? op_i.data[0] : final_q[state_d];
  assign state_ext = 9'(state_d);

  always_ff @(posedge clk_i) begin
    if (alpha_we) begin
      alpha_q[ls_idx] <= op_i.data;
    end
    if (final_we) begin
      final_q[fs_idx] <= op_i.data[0];
    end
    if (mem_we) begin
      trans_mem[waddr] <= op_i.data;
    end
    if (mem_re) begin
      next_q <= trans_mem[raddr];
    end
    if (res_load) begin
      out_state_q <= state_ext[StateW-1:0];
      out_acc_q   <= mark && !ill_d;
      out_ill_q   <= ill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bk_q        <= BK_IDLE;
      state_q     <= '0;
      ill_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bk_q        <= bk_d;
      state_q     <= state_d;
      ill_q       <= ill_d;
      out_valid_q <= res_load || (out_valid_q && !out_ready_i);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_state_o   = out_state_q;
  assign out_accept_o  = out_acc_q;
  assign out_illegal_o = out_ill_q;

endmodule

FILE: hw/rtl/table_driven_dfa_matcher.sv
// Table-driven DFA matcher. Items arrive on the slave stream with the opcode in tuser
// and are parked in a two-entry queue, so the input side keeps taking transactions
// while a result waits on the master stream, until the queue is full. Load, start,
// unused-opcode items and a symbol that matches no letter or comes after the illegal
// flag is set are handled in IDLE. A symbol that matches a letter while the flag is clear
// also passes FETCH: alphabet search and transition memory read in IDLE, range check and
// state update in FETCH. The present state feeds the next symbol, so symbols are handled
// one at a time: no new item is taken until a symbol's result is loaded. Every item
// returns exactly one result. The tables are not cleared by reset and must be loaded
// before use; the registers states_in_use (address 0) and letters_in_use (address 4)
// reset to 1. The user must write them only while the block is idle; it is not enforced.
module table_driven_dfa_matcher
  import tdfa_pkg::*;
#(
  parameter int unsigned MAX_STATES  = 32,
  parameter int unsigned MAX_LETTERS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // slot[4:0], letter_slot[9:5], data[17:10], zeros
  input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // current_state[4:0], accepting[5], illegal[6], zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tdfa_cfg_t         cfg_q;
  tdfa_op_t          op;
  logic              op_valid;
  logic              pop;
  logic              cfg_we;
  logic [StateW-1:0] out_state;
  logic              out_accept;
  logic              out_illegal;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.states_in_use  <= CfgW'(1);
      cfg_q.letters_in_use <= CfgW'(1);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_STATES:  cfg_q.states_in_use  <= pwdata[CfgW-1:0];
        REG_LETTERS: cfg_q.letters_in_use <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STATES:  prdata = {26'b0, cfg_q.states_in_use};
      REG_LETTERS: prdata = {26'b0, cfg_q.letters_in_use};
      default:     prdata = '0;
    endcase
  end

  tdfa_front #(
    .MAX_STATES (MAX_STATES),
    .MAX_LETTERS(MAX_LETTERS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_opcode_i(s_axis_tuser),
    .in_slot_i  (s_axis_tdata[4:0]),
    .in_lslot_i (s_axis_tdata[9:5]),
    .in_data_i  (s_axis_tdata[17:10]),
    .op_valid_o (op_valid),
    .op_o       (op),
    .pop_i      (pop)
  );

  tdfa_back #(
    .MAX_STATES (MAX_STATES),
    .MAX_LETTERS(MAX_LETTERS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .op_valid_i   (op_valid),
    .op_i         (op),
    .pop_o        (pop),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_state_o  (out_state),
    .out_accept_o (out_accept),
    .out_illegal_o(out_illegal)
  );

  assign m_axis_tdata = {1'b0, out_illegal, out_accept, out_state};

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> op_valid)
    else $error("queue popped while empty");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> op_valid)
    else $error("input stalled with an empty queue");

  a_accept_excludes_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[5] && m_axis_tdata[6]))
    else $error("result both accepting and illegal");

endmodule

FILE: sim/tb.sv
module tb;
  import tdfa_pkg::*;

  localparam int MAX_S = 32;
  localparam int MAX_L = 32;
  localparam int GEN = 0;
  localparam int CHK = 1;
  localparam int PHASES = 9;
  localparam int RANDOM_PER_PHASE = 165;
  localparam logic [OpcodeW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OpcodeW-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [SlotW-1:0]   slot;
    logic [SlotW-1:0]   lslot;
    logic [DataW-1:0]   data;
  } dfa_item_t;

  typedef struct packed {
    logic [StateW-1:0] state;
    logic              accepting;
    logic              illegal;
  } dfa_status_t;

  typedef enum {MISS_NONE, MISS_LETTER, MISS_FINAL, MISS_TRANS} miss_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  table_driven_dfa_matcher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Two copies of the automaton: one steers stimulus generation, one predicts results.
  bit [7:0]        letter_tab [2][MAX_L];
  bit              letter_ok  [2][MAX_L];
  bit              final_tab  [2][MAX_S];
  bit              final_ok   [2][MAX_S];
  bit [7:0]        next_tab   [2][MAX_S*MAX_L];
  bit              next_ok    [2][MAX_S*MAX_L];
  bit [StateW-1:0] cur_state  [2] = '{0, 0};
  bit              bad_seen   [2] = '{0, 0};
  int unsigned     cfg_states [2] = '{1, 1};
  int unsigned     cfg_letters[2] = '{1, 1};

  dfa_item_t   item_q[$];
  dfa_status_t expected_status_q[$];
  dfa_item_t   item_on_bus;
  dfa_status_t bus_status;
  miss_e       bus_miss;
  int          bus_miss_idx;
  dfa_status_t want;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          send_calm = 0;
  int          recv_calm = 0;

  int unsigned phase_states  [PHASES] = '{4, 32, 0, 63, 2, 7, 32, 1, 20};
  int unsigned phase_letters [PHASES] = '{3, 32, 5, 63, 0, 4, 1, 32, 16};

  function automatic dfa_item_t mk_item(input logic [OpcodeW-1:0] op,
                                        input logic [SlotW-1:0] slot,
                                        input logic [SlotW-1:0] lslot,
                                        input logic [DataW-1:0] data);
    dfa_item_t it;
    it.opcode = op;
    it.slot = slot;
    it.lslot = lslot;
    it.data = data;
    return it;
  endfunction

  // Applies one item to automaton copy m; with commit low the copy is left untouched.
  // The first table entry that the item would read before it was ever written is reported.
  function automatic void dfa_step(input int m, input dfa_item_t it, input bit commit,
                                   output dfa_status_t res, output miss_e miss_kind,
                                   output int miss_idx);
    int unsigned nl;
    int unsigned nst;
    int j;
    int idx;
    bit found;
    bit [StateW-1:0] ps;
    bit bad;
    bit fm;
    bit fm_known;
    nl = (cfg_letters[m] > MAX_L) ? MAX_L : cfg_letters[m];
    nst = (cfg_states[m] > MAX_S) ? MAX_S : cfg_states[m];
    ps = cur_state[m];
    bad = bad_seen[m];
    miss_kind = MISS_NONE;
    miss_idx = 0;
    if (it.opcode == OP_START) begin
      ps = '0;
      bad = 1'b0;
    end else if (it.opcode == OP_SYMBOL && !bad) begin
      j = 0;
      found = 1'b0;
      while (j < int'(nl) && !found && miss_kind == MISS_NONE) begin
        if (!letter_ok[m][j]) begin
          miss_kind = MISS_LETTER;
          miss_idx = j;
        end else if (letter_tab[m][j] == it.data) begin
          found = 1'b1;
        end else begin
          j++;
        end
      end
      if (miss_kind == MISS_NONE) begin
        if (!found) begin
          bad = 1'b1;
        end else begin
          idx = int'(ps) * MAX_L + j;
          if (!next_ok[m][idx]) begin
            miss_kind = MISS_TRANS;
            miss_idx = idx;
          end else if (next_tab[m][idx] >= nst) begin
            bad = 1'b1;
          end else begin
            ps = next_tab[m][idx][StateW-1:0];
          end
        end
      end
    end
    if (it.opcode == OP_LOAD_FINAL && it.slot == ps) begin
      fm = it.data[0];
      fm_known = 1'b1;
    end else begin
      fm = final_tab[m][ps];
      fm_known = final_ok[m][ps];
    end
    if (miss_kind == MISS_NONE && !fm_known) begin
      miss_kind = MISS_FINAL;
      miss_idx = ps;
    end
    res.state = ps;
    res.accepting = fm && !bad;
    res.illegal = bad;
    if (commit) begin
      case (it.opcode)
        OP_LOAD_LETTER: begin
          letter_tab[m][it.slot] = it.data;
          letter_ok[m][it.slot] = 1'b1;
        end
        OP_LOAD_FINAL: begin
          final_tab[m][it.slot] = it.data[0];
          final_ok[m][it.slot] = 1'b1;
        end
        OP_LOAD_TRANS: begin
          next_tab[m][int'(it.slot) * MAX_L + int'(it.lslot)] = it.data;
          next_ok[m][int'(it.slot) * MAX_L + int'(it.lslot)] = 1'b1;
        end
        default: ;
      endcase
      cur_state[m] = ps;
      bad_seen[m] = bad;
    end
  endfunction

  function automatic logic [DataW-1:0] pick_letter();
    if ($urandom_range(99) < 90) return 8'h40 + 8'($urandom_range(15));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [DataW-1:0] pick_next();
    int unsigned nst;
    nst = (cfg_states[GEN] > MAX_S) ? MAX_S : cfg_states[GEN];
    if (nst == 0) nst = 1;
    if ($urandom_range(99) < 88) return 8'($urandom_range(nst - 1));
    return 8'($urandom_range(255));
  endfunction

  function automatic dfa_item_t fill_for(input miss_e kind, input int idx);
    case (kind)
      MISS_LETTER: return mk_item(OP_LOAD_LETTER, 5'(idx), 5'($urandom()), pick_letter());
      MISS_FINAL:  return mk_item(OP_LOAD_FINAL, 5'(idx), 5'($urandom()), 8'($urandom()));
      default:     return mk_item(OP_LOAD_TRANS, 5'(idx / MAX_L), 5'(idx % MAX_L), pick_next());
    endcase
  endfunction

  // Queues an item, preceded by loads for any table entry it would otherwise read unwritten.
  // A filling load reads only the present state's final mark, so it can only miss on that mark.
  task automatic queue_item(input dfa_item_t it);
    dfa_status_t st;
    miss_e mk;
    miss_e fmk;
    int mi;
    int fmi;
    dfa_item_t fill;
    dfa_step(GEN, it, 1'b0, st, mk, mi);
    while (mk != MISS_NONE) begin
      fill = fill_for(mk, mi);
      dfa_step(GEN, fill, 1'b0, st, fmk, fmi);
      if (fmk != MISS_NONE) fill = fill_for(fmk, fmi);
      dfa_step(GEN, fill, 1'b1, st, fmk, fmi);
      item_q.push_back(fill);
      dfa_step(GEN, it, 1'b0, st, mk, mi);
    end
    dfa_step(GEN, it, 1'b1, st, mk, mi);
    item_q.push_back(it);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] value);
    logic [31:0] word;
    word = ($urandom() << CfgW) | 32'(value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_STATES) begin
      cfg_states[GEN] = 32'(value);
      cfg_states[CHK] = 32'(value);
    end else begin
      cfg_letters[GEN] = 32'(value);
      cfg_letters[CHK] = 32'(value);
    end
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      $display("%0t: register %0d read back expected %h actual %h", $time, idx,
               32'(value), prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        dfa_step(CHK, item_on_bus, 1'b1, bus_status, bus_miss, bus_miss_idx);
        expected_status_q.push_back(bus_status);
      end
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(63) == 0) send_calm = 40;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (item_q.size() != 0 && (send_calm > 0 || $urandom_range(99) >= send_idle_pct)) begin
          item_on_bus = item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'b0, item_on_bus.data, item_on_bus.lslot, item_on_bus.slot};
          s_axis_tuser <= item_on_bus.opcode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(63) == 0) recv_calm = 40;
      m_axis_tready <= (recv_calm > 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_status_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_status_q.pop_front();
        if (m_axis_tdata[4:0] !== want.state || m_axis_tdata[5] !== want.accepting ||
            m_axis_tdata[6] !== want.illegal) begin
          $display("%0t: expected state %0d acc %b ill %b actual state %0d acc %b ill %b",
                   $time, want.state, want.accepting, want.illegal, m_axis_tdata[4:0],
                   m_axis_tdata[5], m_axis_tdata[6]);
          errors++;
        end
      end
    end
  end

  initial begin
    int phase;
    int n;
    int roll;
    int unsigned nl_e;
    int unsigned nst_e;
    int j;
    dfa_item_t it;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(REG_STATES, CfgW'(phase_states[phase]));
      write_reg(REG_LETTERS, CfgW'(phase_letters[phase]));
      if (phase == 0) begin
        queue_item(mk_item(OP_LOAD_FINAL, 5'd0, 5'd31, 8'hFF));
        queue_item(mk_item(OP_LOAD_FINAL, 5'd1, 5'd0, 8'hFE));
        queue_item(mk_item(OP_LOAD_FINAL, 5'd31, 5'd31, 8'h01));
        queue_item(mk_item(OP_LOAD_LETTER, 5'd0, 5'd0, 8'h00));
        queue_item(mk_item(OP_LOAD_LETTER, 5'd1, 5'd0, 8'hFF));
        queue_item(mk_item(OP_LOAD_LETTER, 5'd2, 5'd0, 8'h00));
        queue_item(mk_item(OP_LOAD_LETTER, 5'd31, 5'd31, 8'hAA));
        queue_item(mk_item(OP_LOAD_TRANS, 5'd0, 5'd0, 8'h01));
        queue_item(mk_item(OP_LOAD_TRANS, 5'd0, 5'd1, 8'hFF));
        queue_item(mk_item(OP_LOAD_TRANS, 5'd1, 5'd0, 8'h00));
        queue_item(mk_item(OP_LOAD_TRANS, 5'd31, 5'd31, 8'h1F));
        queue_item(mk_item(OP_START, 5'd31, 5'd31, 8'hFF));
        queue_item(mk_item(OP_SYMBOL, 5'd0, 5'd0, 8'h00));
        queue_item(mk_item(OP_SYMBOL, 5'd31, 5'd31, 8'h00));
        queue_item(mk_item(OP_SYMBOL, 5'd0, 5'd0, 8'h55));
        queue_item(mk_item(OP_SYMBOL, 5'd0, 5'd0, 8'h00));
        queue_item(mk_item(OP_SPARE_LO, 5'd31, 5'd0, 8'hFF));
        queue_item(mk_item(OP_SPARE_LO + 3'd1, 5'd10, 5'd21, 8'h5A));
        queue_item(mk_item(OP_SPARE_HI, 5'd0, 5'd31, 8'h00));
        queue_item(mk_item(OP_START, 5'd0, 5'd0, 8'h00));
        queue_item(mk_item(OP_SYMBOL, 5'd0, 5'd0, 8'hFF));
        queue_item(mk_item(OP_SYMBOL, 5'd0, 5'd0, 8'h00));
        queue_item(mk_item(OP_START, 5'd0, 5'd0, 8'h00));
      end
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        nl_e = (cfg_letters[GEN] > MAX_L) ? MAX_L : cfg_letters[GEN];
        nst_e = (cfg_states[GEN] > MAX_S) ? MAX_S : cfg_states[GEN];
        if (nl_e == 0) nl_e = 1;
        if (nst_e == 0) nst_e = 1;
        it = mk_item(OP_SYMBOL, 5'($urandom()), 5'($urandom()), 8'($urandom()));
        roll = $urandom_range(99);
        if (roll < 55) begin
          j = $urandom_range(nl_e - 1);
          if ($urandom_range(99) < 88 && letter_ok[GEN][j]) it.data = letter_tab[GEN][j];
        end else if (roll < 63) begin
          it.opcode = OP_START;
        end else if (roll < 81) begin
          it.opcode = OP_LOAD_TRANS;
          if ($urandom_range(99) < 80) it.slot = 5'($urandom_range(nst_e - 1));
          if ($urandom_range(99) < 80) it.lslot = 5'($urandom_range(nl_e - 1));
          it.data = pick_next();
        end else if (roll < 88) begin
          it.opcode = OP_LOAD_LETTER;
          it.data = pick_letter();
        end else if (roll < 94) begin
          it.opcode = OP_LOAD_FINAL;
          if ($urandom_range(99) < 80) it.slot = 5'($urandom_range(nst_e - 1));
        end else begin
          it.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        queue_item(it);
      end
      while (item_q.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0)
        @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
